// ===== sv/crc16_frame_parser_defines.svh =====
// Assertion macros shared by the frame parser RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef CRC16_FRAME_PARSER_DEFINES_SVH
`define CRC16_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRCFP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/crcfp_pkg.sv =====
// Shared types, constants and the CRC-16/CCITT-FALSE byte step for the frame parser.
// No dependencies; imported by every module of the block.
package crcfp_pkg;

    // Payload store sizing.
    localparam int MAX_PAYLOAD = 32;
    localparam int PAY_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD);

    // Result field widths.
    localparam int LEN_W = 6;
    localparam int IDX_W = 5;

    // Command queue between the parser and the result sequencer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // CRC constants.
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_ONE = 2'd0;
    localparam logic [1:0] REG_START_TWO = 2'd1;
    localparam logic [1:0] REG_VERSION   = 2'd2;

    // Result status codes.
    typedef enum logic [2:0] {
        STATUS_NONE    = 3'd0,
        STATUS_GOOD    = 3'd1,
        STATUS_BAD_VER = 3'd2,
        STATUS_BAD_LEN = 3'd3,
        STATUS_BAD_CRC = 3'd4
    } status_t;

    // One command per accepted item, queued for the result sequencer.
    typedef struct packed {
        status_t          status;
        logic [7:0]       frame_type;
        logic [7:0]       frame_seq;
        logic [LEN_W-1:0] frame_length;
    } cmd_t;

    // Payload store write port.
    typedef struct packed {
        logic              en;
        logic [PAY_AW-1:0] addr;
        logic [7:0]        data;
    } pay_wr_t;

    // Status of the result sequencer seen by the parser.
    typedef struct packed {
        logic bursting;
        logic burst_done;
    } back_stat_t;

    // One byte of CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (x[15])
                x = {x[14:0], 1'b0} ^ CRC_POLY;
            else
                x = {x[14:0], 1'b0};
        end
        return x;
    endfunction

endpackage

// ===== sv/crc16_frame_parser.sv =====
// Top level of the framed packet parser with CRC-16/CCITT-FALSE check.
// Depends on crcfp_pkg, crcfp_front, crcfp_queue, crcfp_back and the defines header.
//
// Each input item (a received byte, or a timeout event when s_tuser is set) is taken by
// the parser front end and produces one queued command; the front end keeps taking one
// item per cycle while the four-entry command queue has room and no payload byte is held
// off. The result sequencer turns each command into one result, or, for a good frame with
// a payload, into one result per payload byte, one per cycle while m_tready holds, after
// the first byte is read from the registered payload store. A payload byte of a new frame
// is held off until the previous good frame has finished reading the store. Results carry
// the status in m_tuser and mark the final result of an item with m_tlast. The
// configuration port is always ready.
`include "crc16_frame_parser_defines.svh"

module crc16_frame_parser
    import crcfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] frame_type, [15:8] frame_seq,
                                   // [21:16] frame_length, [26:22] byte_index,
                                   // [34:27] payload_byte, [39:35] zero
    output logic [2:0]  m_tuser,   // [2:0] status
    output logic        m_tlast    // last
);

    logic       q_full, q_empty, q_push, q_pop;
    cmd_t       push_cmd, pop_cmd;
    pay_wr_t    pay_wr;
    back_stat_t stat;

    // Front end: configuration, parsing and CRC.
    crcfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pay_wr    (pay_wr),
        .stat      (stat)
    );

    // Command queue.
    crcfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    // Result sequencer with the payload store.
    crcfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pay_wr   (pay_wr),
        .q_empty  (q_empty),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .stat     (stat)
    );

    // The store is never written while a burst is reading it.
    `CRCFP_ASSERT_IMPLIES(a_no_write_in_burst, pay_wr.en, !stat.bursting, "payload write during burst")
    // Every accepted item finds room in the queue.
    `CRCFP_ASSERT_IMPLIES(a_queue_room, q_push, !q_full, "command queue overflow")
    // Results other than a good frame are single and therefore last.
    `CRCFP_ASSERT_IMPLIES(a_single_last, m_tvalid && (m_tuser != STATUS_GOOD), m_tlast, "non-good result without last")
    // The end of a burst puts a last result on the output.
    `CRCFP_ASSERT_NEXT(a_burst_end, stat.burst_done, m_tvalid && m_tlast, "burst ended without last result")

endmodule

// ===== sv/crcfp_front.sv =====
// Parser front end: configuration registers, frame state machine and running CRC.
// Depends on crcfp_pkg; pushes one command per item and writes the payload store.
module crcfp_front
    import crcfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd,
    output pay_wr_t    pay_wr,
    input  back_stat_t stat
);

    typedef enum logic [8:0] {
        S_SOF1 = 9'b000000001,
        S_SOF2 = 9'b000000010,
        S_VER  = 9'b000000100,
        S_TYPE = 9'b000001000,
        S_SEQ  = 9'b000010000,
        S_LEN  = 9'b000100000,
        S_PAY  = 9'b001000000,
        S_CRCL = 9'b010000000,
        S_CRCH = 9'b100000000
    } pstate_t;

    pstate_t          state_reg, state_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       low_reg, low_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       seq_reg, seq_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic             busy_reg, busy_next;
    logic [7:0]       start_one_reg, start_two_reg, version_reg;
    logic             accept;
    logic             do_clear;
    logic [LEN_W-1:0] fill_inc;
    logic [7:0]       b;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_one_reg <= 8'd170;
            start_two_reg <= 8'd85;
            version_reg   <= 8'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_ONE: start_one_reg <= cfg_data;
                REG_START_TWO: start_two_reg <= cfg_data;
                REG_VERSION:   version_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Payload bytes wait while the previous good frame still reads the store.
    assign s_tready = !q_full && !((state_reg == S_PAY) && busy_reg);
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;
    assign b        = s_tdata;
    assign fill_inc = fill_reg + LEN_W'(1);

    // Next state of the parser for the item on the input.
    always_comb
    begin
        state_next = state_reg;
        crc_next   = crc_reg;
        low_next   = low_reg;
        type_next  = type_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        fill_next  = fill_reg;
        do_clear   = 1'b0;
        push_cmd   = '0;
        push_cmd.status = STATUS_NONE;
        pay_wr     = '0;

        if (s_tuser)
        begin
            do_clear   = 1'b1;
            state_next = S_SOF1;
        end
        else
        begin
            case (state_reg)
                S_SOF1:
                begin
                    if (b == start_one_reg)
                        state_next = S_SOF2;
                end
                S_SOF2:
                begin
                    if (b == start_two_reg)
                    begin
                        state_next = S_VER;
                        crc_next   = CRC_INIT;
                    end
                    else if (b != start_one_reg)
                    begin
                        state_next = S_SOF1;
                    end
                end
                S_VER:
                begin
                    if (b != version_reg)
                    begin
                        do_clear        = 1'b1;
                        state_next      = (b == start_one_reg) ? S_SOF2 : S_SOF1;
                        push_cmd.status = STATUS_BAD_VER;
                    end
                    else
                    begin
                        crc_next   = crc_step(crc_reg, b);
                        state_next = S_TYPE;
                    end
                end
                S_TYPE:
                begin
                    type_next  = b;
                    crc_next   = crc_step(crc_reg, b);
                    state_next = S_SEQ;
                end
                S_SEQ:
                begin
                    seq_next   = b;
                    crc_next   = crc_step(crc_reg, b);
                    state_next = S_LEN;
                end
                S_LEN:
                begin
                    crc_next  = crc_step(crc_reg, b);
                    fill_next = '0;
                    if (b > LEN_MAX)
                    begin
                        do_clear        = 1'b1;
                        state_next      = S_SOF1;
                        push_cmd.status = STATUS_BAD_LEN;
                    end
                    else
                    begin
                        len_next   = b[LEN_W-1:0];
                        state_next = (b == 8'd0) ? S_CRCL : S_PAY;
                    end
                end
                S_PAY:
                begin
                    pay_wr.en   = accept;
                    pay_wr.addr = fill_reg[PAY_AW-1:0];
                    pay_wr.data = b;
                    fill_next   = fill_inc;
                    crc_next    = crc_step(crc_reg, b);
                    if (fill_inc >= len_reg)
                        state_next = S_CRCL;
                end
                S_CRCL:
                begin
                    low_next   = b;
                    state_next = S_CRCH;
                end
                S_CRCH:
                begin
                    do_clear   = 1'b1;
                    state_next = S_SOF1;
                    if ({b, low_reg} == crc_reg)
                    begin
                        push_cmd.status       = STATUS_GOOD;
                        push_cmd.frame_type   = type_reg;
                        push_cmd.frame_seq    = seq_reg;
                        push_cmd.frame_length = len_reg;
                    end
                    else
                    begin
                        push_cmd.status = STATUS_BAD_CRC;
                    end
                end
                default:
                begin
                    do_clear   = 1'b1;
                    state_next = S_SOF1;
                end
            endcase
        end

        // Parser reset after a timeout, an error or the end of a frame.
        if (do_clear)
        begin
            crc_next  = CRC_INIT;
            low_next  = '0;
            type_next = '0;
            seq_next  = '0;
            len_next  = '0;
            fill_next = '0;
        end
    end

    // A good frame with payload keeps the store locked until its burst is out.
    always_comb
    begin
        busy_next = busy_reg;
        if (accept && (push_cmd.status == STATUS_GOOD) && (push_cmd.frame_length != '0))
            busy_next = 1'b1;
        else if (stat.burst_done)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SOF1;
            crc_reg   <= CRC_INIT;
            low_reg   <= '0;
            type_reg  <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            fill_reg  <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (accept)
            begin
                state_reg <= state_next;
                crc_reg   <= crc_next;
                low_reg   <= low_next;
                type_reg  <= type_next;
                seq_reg   <= seq_next;
                len_reg   <= len_next;
                fill_reg  <= fill_next;
            end
        end
    end

endmodule

// ===== sv/crcfp_queue.sv =====
// Small command queue between the parser and the result sequencer.
// Depends on crcfp_pkg for the command type and depth.
module crcfp_queue
    import crcfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, rptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push, do_pop;

    assign full    = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wptr_reg] <= push_cmd;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + QUEUE_AW'(1);
            if (do_pop)
                rptr_reg <= rptr_reg + QUEUE_AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (QUEUE_AW + 1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (QUEUE_AW + 1)'(1);
        end
    end

endmodule

// ===== sv/crcfp_back.sv =====
// Result sequencer: payload store, burst reader and output register.
// Depends on crcfp_pkg; pops queued commands and drives the result stream.
module crcfp_back
    import crcfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pay_wr_t     pay_wr,
    input  logic        q_empty,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    output back_stat_t  stat
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_SHOW = 2'b10
    } bstate_t;

    logic [7:0]        mem [MAX_PAYLOAD];
    logic [7:0]        rd_data_reg;
    logic              rd_en;
    logic [PAY_AW-1:0] rd_addr;

    bstate_t           bstate_reg, bstate_next;
    logic [PAY_AW-1:0] k_reg, k_next;
    cmd_t              hold_reg, hold_next;

    logic              ovalid_reg;
    status_t           ostatus_reg;
    logic [7:0]        otype_reg, oseq_reg, obyte_reg;
    logic [LEN_W-1:0]  olen_reg;
    logic [IDX_W-1:0]  oidx_reg;
    logic              olast_reg;

    logic              can_load, load, burst_last;
    status_t           ostatus_next;
    logic [7:0]        otype_next, oseq_next, obyte_next;
    logic [LEN_W-1:0]  olen_next;
    logic [IDX_W-1:0]  oidx_next;
    logic              olast_next;

    // Payload store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (pay_wr.en)
            mem[pay_wr.addr] <= pay_wr.data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign can_load   = !ovalid_reg || m_tready;
    assign burst_last = ((LEN_W'(k_reg) + LEN_W'(1)) == hold_reg.frame_length);

    // Sequencer: single results straight from the queue, bursts through the store.
    always_comb
    begin
        bstate_next  = bstate_reg;
        k_next       = k_reg;
        hold_next    = hold_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        load         = 1'b0;
        ostatus_next = STATUS_NONE;
        otype_next   = '0;
        oseq_next    = '0;
        olen_next    = '0;
        oidx_next    = '0;
        obyte_next   = '0;
        olast_next   = 1'b1;
        stat         = '0;

        case (bstate_reg)
            B_IDLE:
            begin
                if (!q_empty && can_load)
                begin
                    q_pop = 1'b1;
                    if ((q_cmd.status == STATUS_GOOD) && (q_cmd.frame_length != '0))
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = '0;
                        k_next      = '0;
                        hold_next   = q_cmd;
                        bstate_next = B_SHOW;
                    end
                    else
                    begin
                        load         = 1'b1;
                        ostatus_next = q_cmd.status;
                        otype_next   = q_cmd.frame_type;
                        oseq_next    = q_cmd.frame_seq;
                        olen_next    = q_cmd.frame_length;
                    end
                end
            end
            B_SHOW:
            begin
                stat.bursting = 1'b1;
                if (can_load)
                begin
                    load         = 1'b1;
                    ostatus_next = STATUS_GOOD;
                    otype_next   = hold_reg.frame_type;
                    oseq_next    = hold_reg.frame_seq;
                    olen_next    = hold_reg.frame_length;
                    oidx_next    = IDX_W'(k_reg);
                    obyte_next   = rd_data_reg;
                    olast_next   = burst_last;
                    if (burst_last)
                    begin
                        stat.burst_done = 1'b1;
                        bstate_next     = B_IDLE;
                    end
                    else
                    begin
                        k_next  = k_reg + PAY_AW'(1);
                        rd_en   = 1'b1;
                        rd_addr = k_reg + PAY_AW'(1);
                    end
                end
            end
            default:
            begin
                bstate_next = B_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg <= B_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            bstate_reg <= bstate_next;
            if (load)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    // Burst bookkeeping and output payload.
    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        hold_reg <= hold_next;
        if (load)
        begin
            ostatus_reg <= ostatus_next;
            otype_reg   <= otype_next;
            oseq_reg    <= oseq_next;
            olen_reg    <= olen_next;
            oidx_reg    <= oidx_next;
            obyte_reg   <= obyte_next;
            olast_reg   <= olast_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = ostatus_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {5'b0, obyte_reg, oidx_reg, olen_reg, oseq_reg, otype_reg};

endmodule
